### rtl/core/brcsw_pkg.sv
package brcsw_pkg;

	localparam int CACHE_BLOCKS_DEF   = 16;
	localparam int BLOCK_BYTES        = 512;
	localparam int MAX_RUN_BLOCKS_DEF = 8192;
	localparam int RUN_ALIGN_MASK_DEF = 8191;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_DONE  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_START = 2'd1,
		CMD_BLOCK = 2'd2,
		CMD_STOP  = 2'd3
	} command_t;

endpackage

### rtl/core/brcsw_ram.sv
module brcsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

### rtl/core/block_ring_cache_sd_writer.sv
// channel | direction | handshake          | payload
// input   | in        | start & !busy      | action, record_length, data_byte, last_byte, write_ok
// result  | out       | strobe (no stall)  | command, card_block, block_count, slot, accepted, error, last
// config  | in        | cfg_valid&cfg_ready| cfg_data (start_block)
// data bytes, stray bytes and ignored completions are accepted in ST_IDLE and handled in ST_EXEC;
// a completion stops the run from ST_EXEC or goes on to ST_ISSUE, which issues the next block or a stop.
// record start does one slot-free check per cycle in ST_FIT, then emits the result.
// a last byte walks the free flags one per cycle in ST_COUNT to count full slots, then ST_TRIG
// emits start when more than 3/4 are full, and the issue result follows on the next cycle.
// arst_n clears all control state; slot storage is not cleared. results cannot stall.
module block_ring_cache_sd_writer #(
	parameter int CACHE_BLOCKS   = brcsw_pkg::CACHE_BLOCKS_DEF,
	parameter int MAX_RUN_BLOCKS = brcsw_pkg::MAX_RUN_BLOCKS_DEF,
	parameter int RUN_ALIGN_MASK = brcsw_pkg::RUN_ALIGN_MASK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [15:0] record_length,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        write_ok,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        strobe,
	output logic [1:0]  command,
	output logic [31:0] card_block,
	output logic [13:0] block_count,
	output logic [3:0]  slot,
	output logic        accepted,
	output logic        error,
	output logic        last
);

	localparam int SW = $clog2(CACHE_BLOCKS);
	localparam int CW = $clog2(CACHE_BLOCKS + 1);
	localparam int AW = $clog2(CACHE_BLOCKS * brcsw_pkg::BLOCK_BYTES);
	localparam logic [SW-1:0] LAST_SLOT = SW'(CACHE_BLOCKS - 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_FIT, ST_COUNT, ST_TRIG, ST_ISSUE
	} state_t;

	typedef enum logic [1:0] {
		MODE_IDLE, MODE_WRITING, MODE_BUSY
	} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [CACHE_BLOCKS-1:0] free_q;
	logic [SW-1:0]     fill_slot_q, drain_slot_q, scan_q;
	logic [8:0]        fill_offset_q;
	logic [31:0]       start_block_q, next_blk_q, run_limit_q;
	logic [CW-1:0]     run_target_q, run_written_q, cnt_q;
	logic [16:0]       need_q;
	logic              open_q;
	logic [1:0]        act_q;
	logic [15:0]       len_q;
	logic [7:0]        byte_q;
	logic              lastb_q, ok_q;

	logic [31:0] limit_w, count_w;
	logic [16:0] room_w, over_w;
	logic        ram_we, fill_ok;
	logic [SW-1:0] scan_nx;
	logic [7:0]  ram_rdata;

	assign limit_w = (next_blk_q + 32'(MAX_RUN_BLOCKS)) & ~32'(RUN_ALIGN_MASK);
	assign count_w = limit_w - next_blk_q;
	assign room_w  = 17'(brcsw_pkg::BLOCK_BYTES) - 17'(fill_offset_q);
	assign over_w  = 17'(len_q) - room_w;
	assign scan_nx = (scan_q == LAST_SLOT) ? '0 : scan_q + 1'b1;
	assign fill_ok = free_q[fill_slot_q];
	assign ram_we  = (state_q == ST_EXEC) && (act_q == brcsw_pkg::ACT_BYTE) && open_q && fill_ok;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	// slot byte storage
	brcsw_ram #(.WIDTH(8), .DEPTH(CACHE_BLOCKS * brcsw_pkg::BLOCK_BYTES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (AW'({fill_slot_q, fill_offset_q})),
		.wdata (byte_q),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; mode_q <= MODE_IDLE; free_q <= '1;
			fill_slot_q <= '0; drain_slot_q <= '0; fill_offset_q <= '0;
			start_block_q <= '0; next_blk_q <= '0; run_limit_q <= '0;
			run_target_q <= '0; run_written_q <= '0; open_q <= 1'b0;
			scan_q <= '0; cnt_q <= '0; need_q <= '0;
			strobe <= 1'b0; command <= '0; card_block <= '0; block_count <= '0;
			slot <= '0; accepted <= 1'b0; error <= 1'b0; last <= 1'b0;
			act_q <= '0; len_q <= '0; byte_q <= '0; lastb_q <= 1'b0; ok_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						start_block_q <= cfg_data;
						if (mode_q == MODE_IDLE)
							next_blk_q <= cfg_data;
					end
					if (start) begin
						act_q <= action; len_q <= record_length; byte_q <= data_byte;
						lastb_q <= last_byte; ok_q <= write_ok;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					case (act_q)
						brcsw_pkg::ACT_START: begin
							scan_q <= fill_slot_q;
							if (len_q > 16'(room_w))
								need_q <= 17'd1 + 17'((over_w + 17'd511) >> 9);
							else
								need_q <= 17'd1;
							state_q <= ST_FIT;
						end
						brcsw_pkg::ACT_BYTE: begin
							if (open_q) begin
								if (fill_ok) begin
									if (fill_offset_q == 9'd511) begin
										fill_offset_q <= '0;
										free_q[fill_slot_q] <= 1'b0;
										fill_slot_q <= (fill_slot_q == LAST_SLOT) ? '0
										               : fill_slot_q + 1'b1;
									end else
										fill_offset_q <= fill_offset_q + 1'b1;
								end
								if (lastb_q) begin
									open_q <= 1'b0;
									scan_q <= '0; cnt_q <= '0;
									state_q <= ST_COUNT;
								end
							end
						end
						brcsw_pkg::ACT_DONE: begin
							if (mode_q == MODE_BUSY) begin
								command <= brcsw_pkg::CMD_NONE; card_block <= '0;
								block_count <= '0; slot <= '0; accepted <= 1'b0;
								error <= 1'b0; last <= 1'b1;
								if (!ok_q) begin
									mode_q <= MODE_IDLE; strobe <= 1'b1; error <= 1'b1;
								end else begin
									run_written_q <= run_written_q + 1'b1;
									if (run_written_q + 1'b1 == run_target_q
									    || next_blk_q == run_limit_q) begin
										mode_q <= MODE_IDLE; strobe <= 1'b1;
										command <= brcsw_pkg::CMD_STOP;
									end else begin
										mode_q <= MODE_WRITING;
										state_q <= ST_ISSUE;
									end
								end
							end
						end
						default: ;
					endcase
				end
				// one slot-free check per cycle
				ST_FIT: begin
					if (len_q == 16'd0 || need_q == 17'd0 || !free_q[scan_q]
					    || need_q > 17'(CACHE_BLOCKS)) begin
						strobe <= 1'b1; command <= brcsw_pkg::CMD_NONE;
						card_block <= '0; block_count <= '0; slot <= '0; error <= 1'b0;
						last <= 1'b1;
						if (len_q == 16'd0) begin
							accepted <= 1'b1; open_q <= 1'b0;
						end else begin
							accepted <= (need_q == 17'd0);
							open_q <= (need_q == 17'd0);
						end
						state_q <= ST_IDLE;
					end else begin
						need_q <= need_q - 1'b1;
						scan_q <= scan_nx;
					end
				end
				// count full slots one flag per cycle
				ST_COUNT: begin
					cnt_q <= cnt_q + CW'(!free_q[scan_q]);
					scan_q <= scan_nx;
					if (scan_q == LAST_SLOT)
						state_q <= ST_TRIG;
				end
				ST_TRIG: begin
					state_q <= ST_IDLE;
					if ((4 * int'(cnt_q) > 3 * CACHE_BLOCKS) && mode_q == MODE_IDLE
					    && count_w != 32'd0) begin
						run_limit_q <= limit_w; run_target_q <= cnt_q;
						run_written_q <= '0; mode_q <= MODE_WRITING;
						strobe <= 1'b1; command <= brcsw_pkg::CMD_START;
						card_block <= next_blk_q; block_count <= count_w[13:0];
						slot <= '0; accepted <= 1'b0; error <= 1'b0; last <= 1'b0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_IDLE;
					strobe <= 1'b1; block_count <= '0; accepted <= 1'b0;
					error <= 1'b0; last <= 1'b1;
					if (free_q[drain_slot_q]) begin
						mode_q <= MODE_IDLE; command <= brcsw_pkg::CMD_STOP;
						card_block <= '0; slot <= '0;
					end else begin
						command <= brcsw_pkg::CMD_BLOCK; card_block <= next_blk_q;
						slot <= 4'(drain_slot_q);
						free_q[drain_slot_q] <= 1'b1;
						drain_slot_q <= (drain_slot_q == LAST_SLOT) ? '0
						                : drain_slot_q + 1'b1;
						next_blk_q <= next_blk_q + 1'b1;
						mode_q <= MODE_BUSY;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a start command is always followed by an issue result
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && command == brcsw_pkg::CMD_START |=> strobe && last)
		else $error("start without follow-up");
	// a block command leaves the writer waiting for a completion
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && command == brcsw_pkg::CMD_BLOCK |-> mode_q == MODE_BUSY)
		else $error("block issued but writer not busy");
	// no input is taken while sequencing
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COUNT |-> busy && !cfg_ready)
		else $error("ready during count");

endmodule
